### hw/rtl/button_debounce_press_classifier_core_macros.svh
// assertion macros used by the debounce press classifier rtl
`ifndef BUTTON_DEBOUNCE_PRESS_CLASSIFIER_CORE_MACROS_SVH
`define BUTTON_DEBOUNCE_PRESS_CLASSIFIER_CORE_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every rising clock edge outside reset
`define BDPC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// condition must never be seen outside reset
`define BDPC_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define BDPC_ASSERT(lbl, clk, rst, prop, msg)
`define BDPC_ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif

`endif

### hw/rtl/bdpc_pkg.sv
// types and constants of the debounce press classifier
`default_nettype none
package bdpc_pkg;

   // configuration register layout
   localparam int CFG_WIDTH      = 16;
   localparam int CSR_INDEX_BITS = 2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_DEBOUNCE_IDX = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MEDIUM_IDX   = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LONG_IDX     = 2'd2;

   localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RESET = 16'd50;
   localparam logic [CFG_WIDTH-1:0] MEDIUM_RESET   = 16'd1000;
   localparam logic [CFG_WIDTH-1:0] LONG_RESET     = 16'd3000;

   // tick counter width default
   localparam int COUNT_BITS_DEFAULT = 16;

   // button levels, active low
   localparam logic LEVEL_PRESSED  = 1'b0;
   localparam logic LEVEL_RELEASED = 1'b1;

   typedef enum logic [1:0] {
      EV_PRESSED = 2'd0,
      EV_SHORT   = 2'd1,
      EV_MEDIUM  = 2'd2,
      EV_LONG    = 2'd3
   } event_code_type;

   typedef struct packed {
      logic [CFG_WIDTH-1:0] debounce_ticks;
      logic [CFG_WIDTH-1:0] medium_ticks;
      logic [CFG_WIDTH-1:0] long_ticks;
   } cfg_type;

   typedef struct packed {
      logic           valid;
      event_code_type code;
   } evt_type;

   typedef struct packed {
      logic stable_level;
   } stat_type;

endpackage
`default_nettype wire

### hw/rtl/bdpc_chan_if.sv
// valid/ready channels for sample and event words
`default_nettype none
interface bdpc_req_if;
   logic valid;
   logic ready;
   logic raw_level;

   modport source (output valid, output raw_level, input ready);
   modport sink   (input valid, input raw_level, output ready);
endinterface

interface bdpc_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] event_code;

   modport source (output valid, output event_code, input ready);
   modport sink   (input valid, input event_code, output ready);
endinterface
`default_nettype wire

### hw/rtl/button_debounce_press_classifier_core.sv
// top level of the button debounce and press length classifier
//
//  channel  dir  payload            meaning
//  req      in   raw_level  (1b)    one button sample per tick, 0 pressed
//  rsp      out  event_code (2b)    pressed, short, medium or long press
//  csr      in   index 2b, data 16b debounce, medium and long thresholds
//
// one sample word per clock while the event word is not stalled; a sample
// passes the input register, then decision logic into the result register
// reset is synchronous, loads the csr reset values and clears debounce state and both valids
// a stalled event word holds the result register, which then holds the
// input register; req ready drops only when both are full
`default_nettype none
`include "button_debounce_press_classifier_core_macros.svh"
module button_debounce_press_classifier_core #(
   parameter int COUNT_BITS = bdpc_pkg::COUNT_BITS_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   bdpc_req_if.sink                                 req_chan,
   bdpc_rsp_if.source                               rsp_chan,
   input  wire logic                                csr_wr_en,
   input  wire logic [bdpc_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [bdpc_pkg::CFG_WIDTH-1:0]      csr_wdata
);
   import bdpc_pkg::*;

   cfg_type  cfg;
   evt_type  evt;
   stat_type stat;

   // input register
   logic in_valid_ff, in_valid_in;
   logic in_raw_ff, in_raw_in;
   // the held sample moves on whenever the result slot is free or draining
   logic advance;
   logic step;

   assign advance        = !rsp_chan.valid || rsp_chan.ready;
   assign step           = in_valid_ff && advance;
   assign req_chan.ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_raw_in   = in_raw_ff;
      if (req_chan.valid && req_chan.ready) begin
         in_valid_in = 1'b1;
         in_raw_in   = req_chan.raw_level;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_raw_ff <= in_raw_in;
   end

   // configuration registers
   bdpc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // debounce, press timing and event decision, state advances per step
   bdpc_classify #(
      .COUNT_BITS (COUNT_BITS)
   ) u_classify (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .raw_level (in_raw_ff),
      .cfg       (cfg),
      .evt       (evt),
      .stat      (stat)
   );

   // event word register toward the consumer
   bdpc_out_reg u_out_reg (
      .clock    (clock),
      .reset    (reset),
      .evt      (evt),
      .rsp_chan (rsp_chan)
   );

   // an event only fires into a free or draining result slot
   `BDPC_ASSERT_NEVER(a_no_overwrite, clock, reset, evt.valid && rsp_chan.valid && !rsp_chan.ready, "event overwrote a pending word")
   // every decided event shows up as a valid word next cycle
   `BDPC_ASSERT(a_evt_lands, clock, reset, evt.valid |=> rsp_chan.valid, "event word lost")
   // a pressed event leaves the stable level pressed
   `BDPC_ASSERT(a_press_level, clock, reset, (evt.valid && evt.code == EV_PRESSED) |=> (stat.stable_level == LEVEL_PRESSED), "pressed event without stable press")
   // a classified release leaves the stable level released
   `BDPC_ASSERT(a_release_level, clock, reset, (evt.valid && evt.code != EV_PRESSED) |=> (stat.stable_level == LEVEL_RELEASED), "release event without stable release")
endmodule
`default_nettype wire

### hw/rtl/bdpc_csr.sv
// configuration registers: debounce delay and press thresholds
`default_nettype none
module bdpc_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_wr_en,
   input  wire logic [bdpc_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [bdpc_pkg::CFG_WIDTH-1:0]      csr_wdata,
   output bdpc_pkg::cfg_type                        cfg
);
   import bdpc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_DEBOUNCE_IDX: cfg_in.debounce_ticks = csr_wdata;
            CSR_MEDIUM_IDX:   cfg_in.medium_ticks   = csr_wdata;
            CSR_LONG_IDX:     cfg_in.long_ticks     = csr_wdata;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ticks <= DEBOUNCE_RESET;
         cfg_ff.medium_ticks   <= MEDIUM_RESET;
         cfg_ff.long_ticks     <= LONG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;
endmodule
`default_nettype wire

### hw/rtl/bdpc_classify.sv
// debounce state, press timer and event decision for one sample
`default_nettype none
module bdpc_classify #(
   parameter int COUNT_BITS = bdpc_pkg::COUNT_BITS_DEFAULT
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         step,
   input  wire logic         raw_level,
   input  wire bdpc_pkg::cfg_type cfg,
   output bdpc_pkg::evt_type evt,
   output bdpc_pkg::stat_type stat
);
   import bdpc_pkg::*;

   localparam int CMP_BITS = (COUNT_BITS > CFG_WIDTH) ? COUNT_BITS : CFG_WIDTH;

   logic                  prev_raw_ff, prev_raw_in;
   logic                  stable_ff, stable_in;
   logic [COUNT_BITS-1:0] since_ff, since_in;
   logic [COUNT_BITS-1:0] press_ff, press_in;
   logic [COUNT_BITS-1:0] press_inc;
   logic                  take;

   always_comb begin
      // held-level counter, saturating
      if (raw_level != prev_raw_ff) begin
         since_in = '0;
      end else if (since_ff == {COUNT_BITS{1'b1}}) begin
         since_in = since_ff;
      end else begin
         since_in = since_ff + COUNT_BITS'(1);
      end

      // press length counter, saturating
      if (stable_ff == LEVEL_PRESSED && press_ff != {COUNT_BITS{1'b1}}) begin
         press_inc = press_ff + COUNT_BITS'(1);
      end else begin
         press_inc = press_ff;
      end

      take = (CMP_BITS'(since_in) > CMP_BITS'(cfg.debounce_ticks))
             && (raw_level != stable_ff);

      stable_in   = take ? raw_level : stable_ff;
      prev_raw_in = raw_level;
      press_in    = press_inc;
      evt.valid   = step && take;
      evt.code    = EV_PRESSED;
      if (take && raw_level == LEVEL_PRESSED) begin
         press_in = '0;
      end else if (CMP_BITS'(press_inc) < CMP_BITS'(cfg.medium_ticks)) begin
         evt.code = EV_SHORT;
      end else if (CMP_BITS'(press_inc) < CMP_BITS'(cfg.long_ticks)) begin
         evt.code = EV_MEDIUM;
      end else begin
         evt.code = EV_LONG;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_raw_ff <= LEVEL_RELEASED;
         stable_ff   <= LEVEL_RELEASED;
         since_ff    <= '0;
         press_ff    <= '0;
      end else if (step) begin
         prev_raw_ff <= prev_raw_in;
         stable_ff   <= stable_in;
         since_ff    <= since_in;
         press_ff    <= press_in;
      end
   end

   assign stat.stable_level = stable_ff;
endmodule
`default_nettype wire

### hw/rtl/bdpc_out_reg.sv
// result register holding one event word until taken
`default_nettype none
module bdpc_out_reg (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire bdpc_pkg::evt_type evt,
   bdpc_rsp_if.source        rsp_chan
);
   import bdpc_pkg::*;

   logic           valid_ff, valid_in;
   event_code_type code_ff, code_in;

   always_comb begin
      valid_in = valid_ff;
      code_in  = code_ff;
      if (evt.valid) begin
         valid_in = 1'b1;
         code_in  = evt.code;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff <= code_in;
   end

   assign rsp_chan.valid      = valid_ff;
   assign rsp_chan.event_code = code_ff;
endmodule
`default_nettype wire
